### hw/rtl/fl13_pkg.sv
// Shared types, sizes, tap coefficients and sample conversion for the
// multichannel 13-tap low-pass FIR. No dependencies.
package fl13_pkg;

  localparam int LEADS       = 8;
  localparam int TAPS        = 13;
  localparam int SAMPLE_BITS = 24;

  localparam int SAMPLE_W   = 24;
  localparam int LEAD_W     = 3;
  localparam int FILT_W     = 26;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 4;
  localparam int LEAD_CMP_W = 7;
  localparam int LEAD_IDX_W = (LEADS > 1) ? $clog2(LEADS) : 1;
  localparam int HIST_DEPTH = LEADS * TAPS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int PROD_W     = SAMPLE_BITS + COEF_W;
  localparam int ACC_W      = SAMPLE_BITS + 18;
  localparam int SCALE_DIV  = 32768;
  localparam int SCALE_SH   = $clog2(SCALE_DIV);
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 32;

  localparam logic [LEAD_CMP_W-1:0] LEADS_V = LEAD_CMP_W'(LEADS);

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              clr;
    logic [LEAD_W-1:0] lead;
    sample_t           sample;
  } cmd_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [POS_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      4'd0, 4'd12: c = 16'sd584;
      4'd1, 4'd11: c = -16'sd4408;
      4'd2, 4'd10: c = 16'sd6029;
      4'd3, 4'd9:  c = -16'sd4130;
      4'd4, 4'd8:  c = -16'sd2633;
      4'd5, 4'd7:  c = 16'sd10532;
      4'd6:        c = 16'sd18717;
      default:     c = '0;
    endcase
    return c;
  endfunction

  function automatic sample_t take_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_BITS+SAMPLE_W-1:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, raw};
    return ext[SAMPLE_BITS-1:0];
  endfunction

endpackage

### hw/rtl/fl13_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fl13_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fl13_front.sv
// Front end: accepts input transactions, drops out-of-range leads and
// queues commands in a two-entry queue. Depends on fl13_pkg.
module fl13_front import fl13_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output cmd_t                 q,
  output logic                 q_valid,
  input  logic                 q_ready
);

  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  cmd_t       slot [2];
  cmd_t       c;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    c.clr    = s_tuser;
    c.lead   = s_tdata[LEAD_W-1:0];
    c.sample = take_sample(s_tdata[LEAD_W +: SAMPLE_W]);
  end

  assign keep     = {{(LEAD_CMP_W-LEAD_W){1'b0}}, c.lead} < LEADS_V;
  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid & s_tready & keep;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid & q_ready;
  assign q        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= c;
    end
  end

endmodule

### hw/rtl/fl13_back.sv
// Back end: per-lead history in RAM, shared multiply-accumulate over the
// taps, scaling and output register. Depends on fl13_pkg and fl13_ram.
module fl13_back import fl13_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 q,
  input  logic                 q_valid,
  output logic                 q_ready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic [POS_W-1:0]   TAPS_P = POS_W'(TAPS);
  localparam logic [POS_W-1:0]   LAST_P = POS_W'(TAPS - 1);
  localparam logic [HIST_AW-1:0] TAPS_A = HIST_AW'(TAPS);
  localparam logic [ACC_W-1:0]   RND    = ACC_W'(SCALE_DIV - 1);

  logic [1:0]              state;
  logic [LEAD_W-1:0]       lead_r;
  logic [HIST_AW-1:0]      base;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        k;
  logic [POS_W-1:0]        fill_n;
  logic [POS_W-1:0]        wp   [LEADS];
  logic [POS_W-1:0]        fill [LEADS];

  logic                    s1_go;
  logic                    s1_ok;
  logic [POS_W-1:0]        s1_k;
  logic                    s2_go;
  logic                    s2_last;
  logic                    s3_done;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [FILT_W-1:0]       out_filt;
  logic [LEAD_W-1:0]       out_lead;

  logic [LEAD_IDX_W-1:0]   li;
  logic [POS_W-1:0]        wpos;
  logic [POS_W-1:0]        fcur;
  logic [POS_W-1:0]        wp_next;
  logic [POS_W-1:0]        fill_next;
  logic                    start;
  logic                    ram_we;
  logic [HIST_AW-1:0]      qbase;
  logic [HIST_AW-1:0]      waddr;
  logic [HIST_AW-1:0]      raddr;
  logic [SAMPLE_BITS-1:0]  rdata;
  sample_t                 op;
  logic signed [ACC_W-1:0] adj;
  logic signed [ACC_W-1:0] quo;
  logic                    out_free;

  assign q_ready   = (state == S_IDLE);
  assign li        = LEAD_IDX_W'(q.lead);
  assign wpos      = wp[li];
  assign fcur      = fill[li];
  assign wp_next   = (wpos == LAST_P) ? '0 : wpos + 1'b1;
  assign fill_next = (fcur == TAPS_P) ? fcur : fcur + 1'b1;
  assign start     = q_valid & q_ready;
  assign ram_we    = start & (q.clr == CMD_FILTER);
  assign qbase     = HIST_AW'(q.lead) * TAPS_A;
  assign waddr     = qbase + HIST_AW'(wpos);
  assign raddr     = base + HIST_AW'(pos);
  assign op        = s1_ok ? sample_t'(rdata) : '0;
  assign adj       = acc + (acc[ACC_W-1] ? RND : '0);
  assign quo       = adj >>> SCALE_SH;
  assign out_free  = ~m_tvalid | m_tready;
  assign m_tdata   = {{(M_TDATA_W-FILT_W-LEAD_W){1'b0}}, out_lead, out_filt};

  fl13_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(q.sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      s1_go    <= 1'b0;
      s2_go    <= 1'b0;
      s3_done  <= 1'b0;
      for (int i = 0; i < LEADS; i++) begin
        wp[i]   <= '0;
        fill[i] <= '0;
      end
    end else begin
      s1_go   <= (state == S_RUN);
      s2_go   <= s1_go;
      s3_done <= s2_go & s2_last;
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (q.clr == CMD_CLEAR) begin
              wp[li]   <= '0;
              fill[li] <= '0;
            end else begin
              wp[li]   <= wp_next;
              fill[li] <= fill_next;
              state    <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (k == LAST_P) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (s3_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      lead_r <= q.lead;
      base   <= qbase;
      pos    <= wpos;
      fill_n <= fill_next;
      k      <= '0;
      acc    <= '0;
    end else begin
      if (state == S_RUN) begin
        pos <= (pos == '0) ? LAST_P : pos - 1'b1;
        k   <= k + 1'b1;
      end
      if (s2_go) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    s1_ok   <= pos < fill_n;
    s1_k    <= k;
    prod    <= PROD_W'(op) * PROD_W'(coef(s1_k));
    s2_last <= (s1_k == LAST_P);
    if (state == S_OUT && out_free) begin
      out_filt <= quo[FILT_W-1:0];
      out_lead <= lead_r;
    end
  end

endmodule

### hw/rtl/fir_lowpass_13tap_multichannel.sv
// Top level of the multichannel 13-tap low-pass FIR.
// Depends on fl13_pkg, fl13_front and fl13_back.
//
//  Channel  Handshake            Payload
//  s_       s_tvalid/s_tready    s_tuser command, s_tdata lead and sample
//  m_       m_tvalid/m_tready    m_tdata filtered value and lead
//
// In the back end a filter transaction stores the sample, walks the taps
// through the single multiply-accumulate unit, drains its pipeline and
// loads the output register. A clear resets the lead's write position and
// fill count only. Out-of-range leads are dropped at the input.
// Reset clears the write positions and fill counts of all leads.
// A two-entry queue keeps input transactions flowing while the back end
// works or waits on m_tready.
module fir_lowpass_13tap_multichannel import fl13_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // lead[2:0], sample[26:3], zero
  input  logic                 s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // filtered[25:0], out_lead[28:26], zero
);

  cmd_t q;
  logic q_valid;
  logic q_ready;

  fl13_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q       (q),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  fl13_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q       (q),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

### tb/sv/tb_fir_lowpass_13tap_multichannel.sv
// Self-checking testbench for the multichannel 13-tap low-pass FIR: a directed table,
// then random filter and clear transactions, checked against a per-lead tap-sum model.
// Depends on fl13_pkg and fir_lowpass_13tap_multichannel.
module tb_fir_lowpass_13tap_multichannel;
  timeunit 1ns;
  timeprecision 1ps;

  import fl13_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 412;
  localparam int DIR_ROWS       = 26;

  typedef struct packed {
    logic              cmd;
    logic [LEAD_W-1:0] lead;
    logic [23:0]       sample;
    logic              fixed;
    logic [FILT_W-1:0] value;
  } stim_row_t;

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic [LEAD_W-1:0] lead;
  } filt_res_t;

  localparam stim_row_t STIM_TAB [DIR_ROWS] = '{
    '{CMD_FILTER, 3'd0, 24'h7FFFFF, 1'b1, 26'd149503},
    '{CMD_FILTER, 3'd1, 24'h800000, 1'b1, -26'sd149504},
    '{CMD_FILTER, 3'd7, 24'h000000, 1'b1, 26'd0},
    '{CMD_FILTER, 3'd2, 24'hFF8000, 1'b1, -26'sd584},
    '{CMD_FILTER, 3'd0, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_CLEAR,  3'd0, 24'h5A5A5A, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd0, 24'h008000, 1'b1, 26'd584},
    '{CMD_CLEAR,  3'd5, 24'hFFFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd5, 24'hFFFFFF, 1'b1, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h800000, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h800000, 1'b0, 26'd0},
    '{CMD_CLEAR,  3'd3, 24'h000000, 1'b0, 26'd0},
    '{CMD_FILTER, 3'd3, 24'h7FFFFF, 1'b1, 26'd149503}
  };

  localparam int TAP_W [TAPS] = '{
    584, -4408, 6029, -4130, -2633, 10532, 18717,
    10532, -2633, -4130, 6029, -4408, 584
  };

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  logic signed [SAMPLE_BITS-1:0] lead_hist [LEADS][TAPS];
  logic [POS_W-1:0]              lead_wpos [LEADS];
  int                            pat_n     [LEADS];

  filt_res_t pending_filtered [$];
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        fails          = 0;
  int        stall_cycles   = 0;

  fir_lowpass_13tap_multichannel i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic clear_lead_state();
    for (int l = 0; l < LEADS; l++) begin
      lead_wpos[l] = '0;
      pat_n[l] = 0;
      for (int k = 0; k < TAPS; k++) lead_hist[l][k] = '0;
    end
  endtask

  task automatic lowpass_tap_sum(input logic cmd, input logic [LEAD_W-1:0] lead,
                                 input logic [23:0] raw, output bit emits,
                                 output logic [FILT_W-1:0] value);
    int     p;
    longint acc;
    longint quo;
    emits = 1'b0;
    value = '0;
    acc   = 0;
    if (int'(lead) >= LEADS) return;
    if (cmd == CMD_CLEAR) begin
      for (int k = 0; k < TAPS; k++) lead_hist[lead][k] = '0;
      lead_wpos[lead] = '0;
      return;
    end
    p = int'(lead_wpos[lead]);
    if (p >= TAPS) p = 0;
    lead_hist[lead][p] = $signed(raw[SAMPLE_BITS-1:0]);
    p++;
    if (p == TAPS) p = 0;
    lead_wpos[lead] = POS_W'(p);
    for (int k = 0; k < TAPS; k++) begin
      p = (p != 0) ? p - 1 : TAPS - 1;
      acc += longint'(lead_hist[lead][p]) * longint'(TAP_W[k]);
    end
    quo   = acc / longint'(SCALE_DIV);
    value = quo[FILT_W-1:0];
    emits = 1'b1;
  endtask

  task automatic send_item(input logic cmd, input logic [LEAD_W-1:0] lead,
                           input logic [23:0] smp, input logic fixed,
                           input logic [FILT_W-1:0] fixed_val);
    bit                emits;
    logic [FILT_W-1:0] value;
    filt_res_t         res;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, smp, lead};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lowpass_tap_sum(cmd, lead, smp, emits, value);
    if (emits) begin
      res.filtered = fixed ? fixed_val : value;
      res.lead     = lead;
      pending_filtered.push_back(res);
    end
  endtask

  // hold tready random per cycle and check each output transaction
  always @(posedge clk) begin
    filt_res_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_filtered.size() == 0) begin
        if (fails < 10) $display("unexpected result: filtered=%h lead=%0d",
                                 m_tdata[FILT_W-1:0], m_tdata[FILT_W+LEAD_W-1:FILT_W]);
        fails++;
      end else begin
        want = pending_filtered.pop_front();
        if (m_tdata[FILT_W-1:0] !== want.filtered ||
            m_tdata[FILT_W+LEAD_W-1:FILT_W] !== want.lead) begin
          if (fails < 10)
            $display("mismatch: expected filtered=%0d lead=%0d, got filtered=%0d lead=%0d",
                     $signed(want.filtered), want.lead,
                     $signed(m_tdata[FILT_W-1:0]), m_tdata[FILT_W+LEAD_W-1:FILT_W]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic              cmd;
    logic [LEAD_W-1:0] lead;
    logic [23:0]       smp;
    int                mode;
    int                k;
    clear_lead_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(STIM_TAB[r].cmd, STIM_TAB[r].lead, STIM_TAB[r].sample,
                STIM_TAB[r].fixed, STIM_TAB[r].value);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd  = ($urandom_range(99) < 8) ? CMD_CLEAR : CMD_FILTER;
        lead = LEAD_W'($urandom);
        mode = $urandom_range(9);
        case (mode)
          0: smp = 24'h7FFFFF;
          1: smp = 24'h800000;
          2: smp = 24'($signed($urandom_range(511)) - 256);
          3, 4: begin
            // advance the sign pattern that lines up with the taps for peak output
            k = (TAPS - (pat_n[lead] % TAPS)) % TAPS;
            smp = (TAP_W[k] > 0) ? 24'h7FFFFF : 24'h800000;
            pat_n[lead]++;
          end
          default: smp = 24'($urandom);
        endcase
        send_item(cmd, lead, smp, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fails += pending_filtered.size();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
